// File: src/ped_pkg.sv
`default_nettype none
package ped_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int TAG_W      = 8;
   localparam int COL_W      = 3;
   localparam int ROW_IN_W   = 6;
   localparam int LEN_W      = 7;
   localparam int CNT_W      = 4;
   localparam int SUM_W      = 40;
   localparam int DIST_W     = 20;
   localparam int REM_W      = DIST_W + 2;
   localparam int DIFF_W     = SAMPLE_W + 1;
   localparam int PROD_W     = 2 * DIFF_W;
   localparam int STEP_W     = 5;
   localparam int MAX_OUT    = 8;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 7;

   localparam logic [CSR_IDX_W-1:0] REG_VECTOR_LENGTH   = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_REFERENCE_COUNT = 4'd1;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [LEN_W-1:0] VECTOR_LENGTH_RESET   = 7'd64;
   localparam logic [CNT_W-1:0] REFERENCE_COUNT_RESET = 4'd8;

   typedef struct packed {
      logic             capture;
      logic             clear;
      logic             write;
      logic             rd_valid;
      logic [COL_W-1:0] rd_col;
      logic             sq_load;
      logic             sq_step;
      logic [COL_W-1:0] sq_col;
      logic             out_load;
      logic             out_last;
   } cmd_type;

   typedef struct packed {
      logic pipe_busy;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

// File: src/ped_channels.sv
`default_nettype none
interface ped_req_if;
   import ped_pkg::*;
   logic                valid;
   logic                ready;
   logic                op;
   logic [COL_W-1:0]    ref_col;
   logic [TAG_W-1:0]    query_col;
   logic [ROW_IN_W-1:0] row_index;
   logic [SAMPLE_W-1:0] sample;
   modport source (output valid, op, ref_col, query_col, row_index, sample, input ready);
   modport sink (input valid, op, ref_col, query_col, row_index, sample, output ready);
endinterface

interface ped_rsp_if;
   import ped_pkg::*;
   logic              valid;
   logic              ready;
   logic [TAG_W-1:0]  query_tag;
   logic [COL_W-1:0]  ref_index;
   logic [DIST_W-1:0] distance;
   logic              last_of_run;
   modport source (output valid, query_tag, ref_index, distance, last_of_run, input ready);
   modport sink (input valid, query_tag, ref_index, distance, last_of_run, output ready);
endinterface

interface ped_csr_if;
   import ped_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: src/ped_ram.sv
`default_nettype none
module ped_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 512
) (
   input  wire logic                                      clock,
   input  wire logic                                      we,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                          wdata,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                          rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

// File: src/ped_ctrl.sv
`default_nettype none
module ped_ctrl #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_REFS = 8
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic                            req_op,
   input  wire logic [ped_pkg::ROW_IN_W-1:0]    req_row,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [ped_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [ped_pkg::CSR_DATA_W-1:0]  csr_data,
   output ped_pkg::cmd_type                     cmd,
   input  wire ped_pkg::status_type             status
);
   import ped_pkg::*;

   localparam int NACC = (MAX_REFS < MAX_OUT) ? MAX_REFS : MAX_OUT;

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_ACCUM     = 3'd1;
   localparam logic [2:0] ST_DRAIN     = 3'd2;
   localparam logic [2:0] ST_SQRT_LOAD = 3'd3;
   localparam logic [2:0] ST_SQRT_RUN  = 3'd4;
   localparam logic [2:0] ST_OUT       = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              emit_ff, emit_in;
   logic [LEN_W-1:0]  vlen_ff, vlen_in;
   logic [CNT_W-1:0]  rcnt_ff, rcnt_in;

   logic [LEN_W-1:0] len_eff;
   logic [CNT_W-1:0] refs_eff;
   logic             accept;
   logic             row_ok;
   logic             row_last;
   logic             col_last;
   logic             step_last;

   always_comb begin
      if (vlen_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (32'(vlen_ff) > MAX_ROWS) begin
         len_eff = LEN_W'(MAX_ROWS);
      end else begin
         len_eff = vlen_ff;
      end
      if (rcnt_ff == '0) begin
         refs_eff = CNT_W'(1);
      end else if (32'(rcnt_ff) > NACC) begin
         refs_eff = CNT_W'(NACC);
      end else begin
         refs_eff = rcnt_ff;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;
   assign row_ok    = {1'b0, req_row} < len_eff;
   assign row_last  = {1'b0, req_row} == (len_eff - LEN_W'(1));
   assign col_last  = {1'b0, col_ff} == (refs_eff - CNT_W'(1));
   assign step_last = step_ff == STEP_W'(DIST_W - 1);

   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      step_in      = step_ff;
      emit_in      = emit_ff;
      cmd          = '0;
      cmd.rd_col   = col_ff;
      cmd.sq_col   = col_ff;
      cmd.out_last = col_last;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_op == OP_LOAD) begin
                  cmd.write = 1'b1;
               end else if (row_ok) begin
                  cmd.capture = 1'b1;
                  cmd.clear   = (req_row == '0);
                  emit_in     = row_last;
                  col_in      = '0;
                  state_in    = ST_ACCUM;
               end
            end
         end
         ST_ACCUM: begin
            cmd.rd_valid = 1'b1;
            if (col_last) begin
               state_in = ST_DRAIN;
            end else begin
               col_in = col_ff + COL_W'(1);
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               if (emit_ff) begin
                  col_in   = '0;
                  state_in = ST_SQRT_LOAD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SQRT_LOAD: begin
            cmd.sq_load = 1'b1;
            step_in     = '0;
            state_in    = ST_SQRT_RUN;
         end
         ST_SQRT_RUN: begin
            cmd.sq_step = 1'b1;
            step_in     = step_ff + STEP_W'(1);
            if (step_last) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               if (col_last) begin
                  state_in = ST_IDLE;
               end else begin
                  col_in   = col_ff + COL_W'(1);
                  state_in = ST_SQRT_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      vlen_in = vlen_ff;
      rcnt_in = rcnt_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_VECTOR_LENGTH:   vlen_in = csr_data;
            REG_REFERENCE_COUNT: rcnt_in = csr_data[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         col_ff   <= '0;
         step_ff  <= '0;
         emit_ff  <= 1'b0;
         vlen_ff  <= VECTOR_LENGTH_RESET;
         rcnt_ff  <= REFERENCE_COUNT_RESET;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         step_ff  <= step_in;
         emit_ff  <= emit_in;
         vlen_ff  <= vlen_in;
         rcnt_ff  <= rcnt_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQRT_RUN && step_last) |=> (state_ff == ST_OUT))
      else $error("root not handed to output after last step");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACCUM) |-> ({1'b0, col_ff} < refs_eff))
      else $error("column read beyond active count");

   assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load && cmd.out_last) |=> (state_ff == ST_IDLE))
      else $error("run did not end after last result");
endmodule
`default_nettype wire

// File: src/ped_datapath.sv
`default_nettype none
module ped_datapath #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_REFS = 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [ped_pkg::COL_W-1:0]     req_ref_col,
   input  wire logic [ped_pkg::TAG_W-1:0]     req_query_col,
   input  wire logic [ped_pkg::ROW_IN_W-1:0]  req_row,
   input  wire logic [ped_pkg::SAMPLE_W-1:0]  req_sample,
   input  wire ped_pkg::cmd_type              cmd,
   output ped_pkg::status_type                status,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic      [ped_pkg::TAG_W-1:0]     rsp_query_tag,
   output logic      [ped_pkg::COL_W-1:0]     rsp_ref_index,
   output logic      [ped_pkg::DIST_W-1:0]    rsp_distance,
   output logic                               rsp_last
);
   import ped_pkg::*;

   localparam int NACC   = (MAX_REFS < MAX_OUT) ? MAX_REFS : MAX_OUT;
   localparam int CIX_W  = (NACC > 1) ? $clog2(NACC) : 1;
   localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int ADDR_W = CIX_W + ROW_W;
   localparam int DEPTH  = 1 << ADDR_W;

   logic [SAMPLE_W-1:0] x_ff;
   logic [TAG_W-1:0]    tag_ff;
   logic [ROW_W-1:0]    row_ff;

   logic                we;
   logic [ADDR_W-1:0]   waddr;
   logic [ADDR_W-1:0]   raddr;
   logic [SAMPLE_W-1:0] y;

   logic                s1_v_ff;
   logic [CIX_W-1:0]    s1_col_ff;
   logic                s2_v_ff;
   logic [CIX_W-1:0]    s2_col_ff;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [DIFF_W-1:0]   diff;
   logic [DIFF_W-1:0]   mag;

   logic [SUM_W-1:0]    acc_ff [NACC];
   logic [CIX_W-1:0]    acc_idx;
   logic [SUM_W-1:0]    acc_rd;

   logic [SUM_W-1:0]    rad_ff;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic [DIST_W-1:0]   root_ff, root_in;
   logic [REM_W+1:0]    rem_sh;
   logic [REM_W+1:0]    trial;

   logic                out_v_ff;
   logic [TAG_W-1:0]    out_tag_ff;
   logic [COL_W-1:0]    out_idx_ff;
   logic [DIST_W-1:0]   out_dist_ff;
   logic                out_last_ff;

   assign we    = cmd.write && (32'(req_ref_col) < MAX_REFS) && (32'(req_row) < MAX_ROWS);
   assign waddr = {req_ref_col[CIX_W-1:0], ROW_W'(req_row)};
   assign raddr = {cmd.rd_col[CIX_W-1:0], row_ff};

   ped_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (req_sample),
      .raddr (raddr),
      .rdata (y)
   );

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         x_ff   <= req_sample;
         tag_ff <= req_query_col;
         row_ff <= ROW_W'(req_row);
      end
   end

   always_comb begin
      diff    = {x_ff[SAMPLE_W-1], x_ff} - {y[SAMPLE_W-1], y};
      mag     = diff[DIFF_W-1] ? (~diff + DIFF_W'(1)) : diff;
      prod_in = PROD_W'(mag) * PROD_W'(mag);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= cmd.rd_valid;
         s2_v_ff <= s1_v_ff;
      end
      s1_col_ff <= cmd.rd_col[CIX_W-1:0];
      s2_col_ff <= s1_col_ff;
      prod_ff   <= prod_in;
   end

   // one read port shared by the accumulate and the root load
   assign acc_idx = s2_v_ff ? s2_col_ff : cmd.sq_col[CIX_W-1:0];
   assign acc_rd  = acc_ff[acc_idx];

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         for (int i = 0; i < NACC; i++) begin
            acc_ff[i] <= '0;
         end
      end else if (s2_v_ff) begin
         acc_ff[acc_idx] <= acc_rd + SUM_W'(prod_ff);
      end
   end

   // restoring square root, one result bit per step
   always_comb begin
      rem_sh = {rem_ff, rad_ff[SUM_W-1 -: 2]};
      trial  = {2'b00, root_ff, 2'b01};
      if (rem_sh >= trial) begin
         rem_in  = REM_W'(rem_sh - trial);
         root_in = {root_ff[DIST_W-2:0], 1'b1};
      end else begin
         rem_in  = rem_sh[REM_W-1:0];
         root_in = {root_ff[DIST_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sq_load) begin
         rad_ff  <= acc_rd;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (cmd.sq_step) begin
         rad_ff  <= {rad_ff[SUM_W-3:0], 2'b00};
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_v_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_v_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         out_tag_ff  <= tag_ff;
         out_idx_ff  <= cmd.sq_col;
         out_dist_ff <= root_ff;
         out_last_ff <= cmd.out_last;
      end
   end

   assign rsp_valid        = out_v_ff;
   assign rsp_query_tag    = out_tag_ff;
   assign rsp_ref_index    = out_idx_ff;
   assign rsp_distance     = out_dist_ff;
   assign rsp_last         = out_last_ff;
   assign status.pipe_busy = s1_v_ff || s2_v_ff;
   assign status.out_free  = !out_v_ff || rsp_ready;

   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!out_v_ff || rsp_ready))
      else $error("pending result overwritten");

   assert property (@(posedge clock) disable iff (reset)
      cmd.sq_load |-> !(s1_v_ff || s2_v_ff))
      else $error("root started before sums settled");

   assert property (@(posedge clock) disable iff (reset)
      (cmd.write || cmd.capture) |-> !(s1_v_ff || s2_v_ff))
      else $error("new transfer taken while accumulate in flight");
endmodule
`default_nettype wire

// File: src/pairwise_euclidean_distance.sv
// load transfer: the store is written at the edge that takes it
// query element not at the last row: refs reads through the store port, then a drain
// query element at the last row: adds one 20-step root per column
// results leave through an output register; a stalled result holds the next root
// reset clears control state, sums and output valid; the store itself is not cleared
`default_nettype none
module pairwise_euclidean_distance #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_REFS = 8
) (
   input  wire logic clock,
   input  wire logic reset,
   ped_req_if.sink   req_chan,
   ped_rsp_if.source rsp_chan,
   ped_csr_if.sink   csr_chan
);
   import ped_pkg::*;

   cmd_type    cmd;
   status_type status;

   ped_ctrl #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_REFS (MAX_REFS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .req_op    (req_chan.op),
      .req_row   (req_chan.row_index),
      .csr_valid (csr_chan.valid),
      .csr_ready (csr_chan.ready),
      .csr_index (csr_chan.index),
      .csr_data  (csr_chan.data),
      .cmd       (cmd),
      .status    (status)
   );

   ped_datapath #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_REFS (MAX_REFS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_ref_col   (req_chan.ref_col),
      .req_query_col (req_chan.query_col),
      .req_row       (req_chan.row_index),
      .req_sample    (req_chan.sample),
      .cmd           (cmd),
      .status        (status),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .rsp_query_tag (rsp_chan.query_tag),
      .rsp_ref_index (rsp_chan.ref_index),
      .rsp_distance  (rsp_chan.distance),
      .rsp_last      (rsp_chan.last_of_run)
   );
endmodule
`default_nettype wire

// File: dv/ped_distance_check.sv
module ped_distance_check #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_REFS = 8
) (
   input  wire logic clock,
   input  wire logic reset,
   ped_req_if        req,
   ped_rsp_if        rsp,
   ped_csr_if        csr,
   output int        fail_count,
   output int        pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import ped_pkg::*;

   typedef struct packed {
      logic [TAG_W-1:0]  query_tag;
      logic [COL_W-1:0]  ref_index;
      logic [DIST_W-1:0] distance;
      logic              last_of_run;
   } distance_type;

   distance_type        expected_distances[$];
   logic [SAMPLE_W-1:0] ref_matrix [MAX_REFS][MAX_ROWS];
   logic [SUM_W-1:0]    col_sums [MAX_REFS];
   logic [LEN_W-1:0]    length_reg;
   logic [CNT_W-1:0]    count_reg;

   initial begin
      fail_count = 0;
      pending_count = 0;
   end

   function automatic int rows_in_use();
      if (length_reg == 0) return 1;
      if (int'(length_reg) > MAX_ROWS) return MAX_ROWS;
      return int'(length_reg);
   endfunction

   function automatic int refs_in_use();
      int n;
      n = (count_reg == 0) ? 1 : int'(count_reg);
      if (n > MAX_REFS) n = MAX_REFS;
      if (n > MAX_OUT) n = MAX_OUT;
      return n;
   endfunction

   function automatic logic [DIST_W-1:0] floor_root(logic [SUM_W-1:0] value);
      logic [DIST_W-1:0] root;
      logic [DIST_W-1:0] trial;
      root = '0;
      for (int b = DIST_W - 1; b >= 0; b--) begin
         trial = root | (DIST_W'(1) << b);
         if (64'(trial) * 64'(trial) <= 64'(value))
            root = trial;
      end
      return root;
   endfunction

   function automatic bit field_differs(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic accumulate_query(logic [TAG_W-1:0] tag, logic [ROW_IN_W-1:0] row,
                                   logic [SAMPLE_W-1:0] x);
      int           len;
      int           refs;
      longint       diff;
      distance_type result;
      len = rows_in_use();
      refs = refs_in_use();
      if (int'(row) >= len)
         return;
      if (row == 0)
         foreach (col_sums[j]) col_sums[j] = '0;
      for (int j = 0; j < refs; j++) begin
         diff = longint'($signed(x)) - longint'($signed(ref_matrix[j][row]));
         col_sums[j] = col_sums[j] + SUM_W'(diff * diff);
      end
      if (int'(row) != len - 1)
         return;
      for (int j = 0; j < refs; j++) begin
         result.query_tag = tag;
         result.ref_index = COL_W'(j);
         result.distance = floor_root(col_sums[j]);
         result.last_of_run = (j == refs - 1);
         expected_distances.push_back(result);
      end
   endtask

   always @(posedge clock) begin
      distance_type want;
      bit           bad;
      if (reset) begin
         expected_distances.delete();
         foreach (col_sums[j]) col_sums[j] = '0;
         length_reg = VECTOR_LENGTH_RESET;
         count_reg = REFERENCE_COUNT_RESET;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_distances.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result, expected none, actual tag %0d ref %0d %s",
                        $time, rsp.query_tag, rsp.ref_index,
                        $sformatf("distance %0d last %0b", rsp.distance, rsp.last_of_run));
            end else begin
               want = expected_distances.pop_front();
               bad = field_differs("query_tag", want.query_tag, rsp.query_tag)
                   | field_differs("ref_index", want.ref_index, rsp.ref_index)
                   | field_differs("distance", want.distance, rsp.distance)
                   | field_differs("last_of_run", want.last_of_run, rsp.last_of_run);
               if (bad)
                  fail_count++;
            end
         end
         if (csr.valid && csr.ready) begin
            case (csr.index)
               REG_VECTOR_LENGTH: length_reg = csr.data[LEN_W-1:0];
               REG_REFERENCE_COUNT: count_reg = csr.data[CNT_W-1:0];
               default: ;
            endcase
         end
         if (req.valid && req.ready) begin
            if (req.op == OP_LOAD) begin
               if (int'(req.ref_col) < MAX_REFS && int'(req.row_index) < MAX_ROWS)
                  ref_matrix[req.ref_col][req.row_index] = req.sample;
            end else begin
               accumulate_query(req.query_col, req.row_index, req.sample);
            end
         end
      end
      pending_count = expected_distances.size();
   end

endmodule

// File: dv/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ped_pkg::*;

   localparam int ROWS           = 64;
   localparam int REFS           = 8;
   localparam int IDLE_PCT       = 37;
   localparam int ITEM_TARGET    = 400;
   localparam int HOLD_CYCLES    = 400;
   localparam int DRAIN_CYCLES   = 200;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int REG_COUNT      = 2;
   localparam int REG_INDEX_MAX  = (1 << CSR_IDX_W) - 1;

   logic clock = 1'b0;
   logic reset;
   int   fail_count;
   int   pending_count;
   int   results_seen = 0;
   int   quiet_cycles = 0;
   int   items_sent = 0;
   int   cur_len = ROWS;
   int   cur_refs = REFS;
   bit   req_steady;
   bit   loaded [REFS][ROWS];

   ped_req_if req_chan();
   ped_rsp_if rsp_chan();
   ped_csr_if csr_chan();

   pairwise_euclidean_distance #(.MAX_ROWS(ROWS), .MAX_REFS(REFS)) dut (
      .clock,
      .reset,
      .req_chan,
      .rsp_chan,
      .csr_chan
   );

   ped_distance_check #(.MAX_ROWS(ROWS), .MAX_REFS(REFS)) distance_check (
      .clock,
      .reset,
      .req(req_chan),
      .rsp(rsp_chan),
      .csr(csr_chan),
      .fail_count,
      .pending_count
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         results_seen <= results_seen + 1;
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (csr_chan.valid && csr_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // receiver: random stalls, one long hold-off, a quiet stretch with no stalls
   initial begin
      bit held;
      held = 1'b0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && results_seen >= 40) begin
            held = 1'b1;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else if (results_seen >= 100 && results_seen < 200) begin
            rsp_chan.ready <= 1'b1;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   function automatic int clamp(int v, int lo, int hi);
      return (v < lo) ? lo : (v > hi) ? hi : v;
   endfunction

   function automatic logic [SAMPLE_W-1:0] rand_sample();
      case ($urandom_range(9))
         0: return {1'b1, {(SAMPLE_W - 1){1'b0}}};
         1: return {1'b0, {(SAMPLE_W - 1){1'b1}}};
         2: return '0;
         3: return '1;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   task automatic send(logic op, logic [COL_W-1:0] col, logic [TAG_W-1:0] tag,
                       logic [ROW_IN_W-1:0] row, logic [SAMPLE_W-1:0] sample);
      while (!req_steady && $urandom_range(99) < IDLE_PCT) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.op <= op;
      req_chan.ref_col <= col;
      req_chan.query_col <= tag;
      req_chan.row_index <= row;
      req_chan.sample <= sample;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      items_sent++;
      if (op == OP_LOAD)
         loaded[col][row] = 1'b1;
      req_steady = (items_sent >= 150 && items_sent < 250);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data <= data;
      do @(posedge clock); while (!csr_chan.ready);
      @(negedge clock);
      csr_chan.valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_shape(int raw_len, int raw_cnt);
      write_reg(REG_VECTOR_LENGTH, CSR_DATA_W'(raw_len));
      write_reg(REG_REFERENCE_COUNT, {(CSR_DATA_W - CNT_W)'($urandom), CNT_W'(raw_cnt)});
      cur_len = clamp(raw_len, 1, ROWS);
      cur_refs = clamp(raw_cnt, 1, REFS);
   endtask

   // every reference entry a query can read gets written first
   task automatic fill_refs();
      for (int j = 0; j < cur_refs; j++)
         for (int r = 0; r < cur_len; r++)
            if (!loaded[j][r])
               send(OP_LOAD, COL_W'(j), TAG_W'($urandom), ROW_IN_W'(r), rand_sample());
   endtask

   task automatic send_column(logic [TAG_W-1:0] tag, bit broken);
      int n;
      int row;
      n = broken ? $urandom_range(1, cur_len + 3) : cur_len;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < 8)
            send(OP_LOAD, COL_W'($urandom), TAG_W'($urandom), ROW_IN_W'($urandom),
                 rand_sample());
         if (!broken)
            row = i;
         else if ($urandom_range(99) < 75)
            row = $urandom_range(cur_len - 1);
         else
            row = $urandom_range(ROWS - 1);
         send(OP_QUERY, COL_W'($urandom), tag, ROW_IN_W'(row), rand_sample());
      end
   endtask

   task automatic settle();
      req_chan.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin
      int columns;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.op = OP_LOAD;
      req_chan.ref_col = '0;
      req_chan.query_col = '0;
      req_chan.row_index = '0;
      req_chan.sample = '0;
      csr_chan.valid = 1'b0;
      csr_chan.index = '0;
      csr_chan.data = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      set_shape(3, 2);
      send(OP_LOAD, 3'd0, 8'h00, 6'd0, 16'h8000);
      send(OP_LOAD, 3'd0, 8'h00, 6'd1, 16'h7fff);
      send(OP_LOAD, 3'd0, 8'h00, 6'd2, 16'h0000);
      send(OP_LOAD, 3'd1, 8'h00, 6'd0, 16'h7fff);
      send(OP_LOAD, 3'd1, 8'h00, 6'd1, 16'h8000);
      send(OP_LOAD, 3'd1, 8'h00, 6'd2, 16'h0100);
      send(OP_QUERY, 3'd7, 8'hff, 6'd0, 16'h7fff);
      // beyond the length, dropped
      send(OP_QUERY, 3'd0, 8'hff, 6'd63, 16'h1234);
      send(OP_QUERY, 3'd0, 8'hff, 6'd1, 16'h8000);
      send(OP_QUERY, 3'd0, 8'hff, 6'd2, 16'hffff);
      // skipped row
      send(OP_QUERY, 3'd5, 8'h00, 6'd0, 16'h0000);
      send(OP_QUERY, 3'd5, 8'h00, 6'd2, 16'h0000);
      // no row 0, repeated row: sums carry over
      send(OP_QUERY, 3'd2, 8'h5a, 6'd1, 16'h0080);
      send(OP_QUERY, 3'd2, 8'h5a, 6'd1, 16'h0080);
      send(OP_QUERY, 3'd2, 8'h5a, 6'd2, 16'hff00);
      settle();
      write_reg(CSR_IDX_W'(REG_COUNT), '1);
      write_reg(CSR_IDX_W'(REG_INDEX_MAX), '0);
      set_shape(0, 0);
      send(OP_QUERY, 3'd0, 8'h11, 6'd0, 16'h7fff);
      send(OP_QUERY, 3'd0, 8'h12, 6'd5, 16'h0001);
      send(OP_QUERY, 3'd0, 8'h13, 6'd0, 16'h8000);
      settle();

      for (int phase = 0; items_sent < ITEM_TARGET; phase++) begin
         case (phase)
            0: set_shape(127, 1);
            1: set_shape(1, 15);
            default: begin
               if ($urandom_range(99) < 15)
                  set_shape($urandom_range(127), $urandom_range(2));
               else
                  set_shape($urandom_range(1, 8), $urandom_range(15));
            end
         endcase
         if ($urandom_range(99) < 25)
            write_reg(CSR_IDX_W'($urandom_range(REG_COUNT, REG_INDEX_MAX)),
                      CSR_DATA_W'($urandom));
         fill_refs();
         columns = (cur_len > 16) ? $urandom_range(1, 2) : $urandom_range(3, 10);
         for (int c = 0; c < columns; c++)
            send_column(TAG_W'($urandom), $urandom_range(99) < 20);
         settle();
      end

      if (fail_count == 0 && pending_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// File: filelist.f
src/ped_pkg.sv
src/ped_channels.sv
src/ped_ram.sv
src/ped_ctrl.sv
src/ped_datapath.sv
src/pairwise_euclidean_distance.sv
dv/ped_distance_check.sv
dv/tb.sv
